// File: hw/rtl/fbmc_pkg.sv
// fbmc_pkg: shared types, constants and decode helpers for the four-bit core.
// Used by every module of the core; depends on nothing.
`default_nettype none

package fbmc_pkg;

  localparam int RAM_WORDS = 128;
  localparam int RAM_AW    = 7;
  localparam int OUT_R_W   = 11;

  localparam logic [3:0] RAM_RESET = 4'hA;

  typedef struct packed {
    logic [7:0] opcode;
    logic [3:0] k_in;
  } in_item_t;

  typedef struct packed {
    logic [10:0] fetch_address;
    logic [10:0] r_lines;
    logic [4:0]  o_lines;
    logic        status;
  } out_item_t;

  // architectural registers other than the R latch
  typedef struct packed {
    logic [3:0] acc;
    logic [3:0] y;
    logic [2:0] x;
    logic       s;
    logic       sl;
    logic [5:0] pc;
    logic [3:0] pa;
    logic [3:0] pb;
    logic       cl;
    logic [5:0] rc;
    logic       ca;
    logic       cb;
    logic       rch;
    logic [4:0] o;
  } cpu_state_t;

  localparam cpu_state_t ST_RESET = '{
    acc: 4'hA, y: 4'hA, x: 3'd2, s: 1'b0, sl: 1'b0, pc: 6'd0,
    pa: 4'hF, pb: 4'hF, cl: 1'b0, rc: 6'd0, ca: 1'b0, cb: 1'b0,
    rch: 1'b0, o: 5'd0
  };

  // RAM port request from the execute logic
  typedef struct packed {
    logic             we;
    logic [RAM_AW-1:0] wa;
    logic [3:0]       wd;
    logic [RAM_AW-1:0] ra;
  } ram_req_t;

  // immediate fields are stored bit-reversed
  function automatic logic [3:0] rev4(input logic [3:0] v);
    rev4 = {v[0], v[1], v[2], v[3]};
  endfunction

  function automatic logic [2:0] rev3(input logic [2:0] v);
    rev3 = {v[0], v[1], v[2]};
  endfunction

  // add-constant table: reversed immediate plus one, wrapping 16 to 0
  function automatic logic [3:0] add_const(input logic [3:0] v);
    add_const = rev4(v) + 4'd1;
  endfunction

  // 4-bit add, carry in bit 4
  function automatic logic [4:0] add4(input logic [3:0] a, input logic [3:0] b);
    add4 = {1'b0, a} + {1'b0, b};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fbmc_ram.sv
// fbmc_ram: 128x4 data RAM, registered read, per-entry valid bits
// (unwritten entries read 0xA) and write-to-read forwarding. Uses fbmc_pkg.
`default_nettype none

module fbmc_ram (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fbmc_pkg::ram_req_t req,
  output logic [3:0]             rd_data
);
  import fbmc_pkg::*;

  logic [3:0]           mem [RAM_WORDS];
  logic [RAM_WORDS-1:0] vld_r;
  logic [3:0]           mem_q_r;
  logic                 vq_r;
  logic                 fwd_r;
  logic [3:0]           fwd_d_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
    mem_q_r <= mem[req.ra];
    fwd_d_r <= req.wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vq_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.wa] <= 1'b1;
      end
      vq_r  <= vld_r[req.ra];
      // same-entry write this cycle: old data comes out of the array
      fwd_r <= req.we && (req.wa == req.ra);
    end
  end

  assign rd_data = fwd_r ? fwd_d_r : (vq_r ? mem_q_r : RAM_RESET);

endmodule

`default_nettype wire

// File: hw/rtl/fbmc_exec.sv
// fbmc_exec: instruction decode and execute, next state and RAM request.
// Uses fbmc_pkg.
`default_nettype none

module fbmc_exec #(
  parameter int R_LINES = 11
) (
  input  wire fbmc_pkg::in_item_t   item,
  input  wire fbmc_pkg::cpu_state_t st,
  input  wire logic [R_LINES-1:0]   r_in,
  input  wire logic [3:0]           m,
  output fbmc_pkg::cpu_state_t      nxt,
  output logic [R_LINES-1:0]        r_nxt,
  output logic                      we,
  output logic [3:0]                wd
);
  import fbmc_pkg::*;

  logic [7:0]         op;
  logic [3:0]         lo;
  logic [3:0]         bitm;
  logic [4:0]         sum;
  logic [R_LINES-1:0] rsel;
  logic [5:0]         pc_inc;

  assign op     = item.opcode;
  assign lo     = op[3:0];
  assign bitm   = 4'b0001 << {op[0], op[1]};
  assign pc_inc = st.pc + 6'd1;

  always_comb begin
    for (int i = 0; i < R_LINES; i++) begin
      rsel[i] = (st.y == 4'(i));
    end
  end

  always_comb begin
    nxt   = st;
    nxt.pc = pc_inc;
    nxt.s  = 1'b1;
    r_nxt = r_in;
    we    = 1'b0;
    wd    = st.acc;
    sum   = '0;
    if (op[7]) begin
      // branch / call, taken on previous status
      if (st.s) begin
        if (op[6]) begin
          if (st.cl) begin
            nxt.pb = st.pa;
          end else begin
            nxt.rch = st.ca;
            nxt.rc  = pc_inc;
            nxt.pb  = st.pa;
            nxt.pa  = st.pb;
            nxt.cl  = 1'b1;
          end
        end else if (!st.cl) begin
          nxt.pa = st.pb;
        end
        nxt.ca = st.cb;
        nxt.pc = op[5:0];
      end
    end else begin
      case (op[6:4])
        3'd7: begin
          if (lo == 4'hF) begin
            nxt.acc = 4'd0;
          end else begin
            sum     = add4(st.acc, add_const(lo));
            nxt.s   = sum[4];
            nxt.acc = sum[3:0];
          end
        end
        3'd6: begin
          we    = 1'b1;
          wd    = rev4(lo);
          nxt.y = st.y + 4'd1;
        end
        3'd5: nxt.s = (st.y != rev4(lo));
        3'd4: nxt.y = rev4(lo);
        3'd3: begin
          case (lo[3:2])
            2'd0: begin
              we = 1'b1;
              wd = m | bitm;
            end
            2'd1: begin
              we = 1'b1;
              wd = m & ~bitm;
            end
            2'd2: nxt.s = ((m & bitm) != 4'd0);
            default: begin
              case (lo[1:0])
                2'd0: begin
                  sum     = {1'b0, m} + {1'b0, ~st.acc} + 5'd1;
                  nxt.s   = sum[4];
                  nxt.acc = sum[3:0];
                end
                2'd1: begin
                  nxt.s   = (st.acc == 4'd0);
                  nxt.acc = 4'd0 - st.acc;
                end
                2'd2: begin
                  sum     = add4(m, 4'd1);
                  nxt.s   = sum[4];
                  nxt.acc = sum[3:0];
                end
                default: nxt.s = (m != 4'd0);
              endcase
            end
          endcase
        end
        3'd2: begin
          if (lo[3]) begin
            nxt.x = rev3(lo[2:0]);
          end else begin
            case (lo[2:0])
              3'd0: nxt.y = st.acc;
              3'd1: nxt.acc = m;
              3'd2: nxt.y = m;
              3'd3: nxt.acc = st.y;
              3'd4: begin
                we    = 1'b1;
                nxt.s = (st.y != 4'd0);
                nxt.y = st.y - 4'd1;
              end
              3'd5: begin
                we    = 1'b1;
                nxt.s = (st.y == 4'hF);
                nxt.y = st.y + 4'd1;
              end
              3'd6: begin
                we      = 1'b1;
                nxt.acc = 4'd0;
              end
              default: we = 1'b1;
            endcase
          end
        end
        3'd1: nxt.pb = rev4(lo);
        default: begin
          case (lo)
            4'h0: nxt.s = (m != st.acc);
            4'h1: nxt.s = (m >= st.acc);
            4'h2: begin
              nxt.s  = (st.acc != st.y);
              nxt.sl = (st.acc != st.y);
            end
            4'h3: begin
              we      = 1'b1;
              nxt.acc = m;
            end
            4'h4: begin
              sum   = add4(st.y, 4'hF);
              nxt.s = sum[4];
              nxt.y = sum[3:0];
            end
            4'h5: begin
              sum   = add4(st.y, 4'd1);
              nxt.s = sum[4];
              nxt.y = sum[3:0];
            end
            4'h6: begin
              sum     = add4(st.acc, m);
              nxt.s   = sum[4];
              nxt.acc = sum[3:0];
            end
            4'h7: begin
              sum     = add4(m, 4'hF);
              nxt.s   = sum[4];
              nxt.acc = sum[3:0];
            end
            4'h8: nxt.acc = item.k_in;
            4'h9: nxt.x = st.x ^ 3'd4;
            4'hA: nxt.o = {st.sl, st.acc};
            4'hB: nxt.cb = ~st.cb;
            4'hC: begin
              if (!st.x[2]) begin
                r_nxt = r_in & ~rsel;
              end
            end
            4'hD: begin
              if (!st.x[2]) begin
                r_nxt = r_in | rsel;
              end
            end
            4'hE: nxt.s = (item.k_in != 4'd0);
            default: begin
              nxt.pa = st.pb;
              if (st.cl) begin
                nxt.ca = st.rch;
                nxt.pc = st.rc;
                nxt.cl = 1'b0;
              end
            end
          endcase
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fbmc_obuf.sv
// fbmc_obuf: result output register plus one skid entry.
// Uses fbmc_pkg.
`default_nettype none

module fbmc_obuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire fbmc_pkg::out_item_t push_data,
  output logic                     ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fbmc_pkg::out_item_t      out_data
);
  import fbmc_pkg::*;

  logic      out_v_r;
  logic      skid_v_r;
  out_item_t out_d_r;
  out_item_t skid_d_r;

  assign ready     = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_d_r <= skid_d_r;
      end else if (push) begin
        out_d_r <= push_data;
      end
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/four_bit_microcontroller_core.sv
// four_bit_microcontroller_core: top level of the four-bit microcontroller core.
// Depends on fbmc_pkg, fbmc_ram, fbmc_exec and fbmc_obuf.
//
// Usage
//   in_*  : one request per instruction: opcode fetched at the last reported
//           fetch address, plus the K lines sampled for it.
//   out_* : one result per request: next fetch address, R lines, O lines and
//           status, in request order.
//   A result is registered in the output register, or in the skid entry
//   while the receiver stalls. Throughput: one instruction per cycle while
//   in_ready is high, set by the single read-modify-write pass over the data
//   RAM; the next instruction's RAM read is issued with the address this one leaves.
//   Reset (rst_n low, synchronous): registers take their power-on values,
//   RAM valid bits clear so every RAM word reads 0xA until written; no
//   clearing pass, requests are taken as soon as reset is released.
//   Receiver stall: one further result is held in a skid entry; in_ready
//   then drops until out_ready drains it.
`default_nettype none

module four_bit_microcontroller_core #(
  parameter int R_LINES = 11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fbmc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fbmc_pkg::out_item_t      out_data
);
  import fbmc_pkg::*;

  cpu_state_t         st_r;
  cpu_state_t         st_nxt;
  cpu_state_t         ex_nxt;
  logic [R_LINES-1:0] r_lat_r;
  logic [R_LINES-1:0] r_lat_nxt;
  logic [R_LINES-1:0] ex_r_nxt;
  logic               ex_we;
  logic [3:0]         ex_wd;
  logic [3:0]         ram_m;
  logic               accept;
  ram_req_t           ram_req;
  out_item_t          res;
  logic [OUT_R_W-1:0] r_view;

  assign accept = in_valid && in_ready;

  fbmc_exec #(.R_LINES(R_LINES)) u_exec (
    .item  (in_data),
    .st    (st_r),
    .r_in  (r_lat_r),
    .m     (ram_m),
    .nxt   (ex_nxt),
    .r_nxt (ex_r_nxt),
    .we    (ex_we),
    .wd    (ex_wd)
  );

  assign st_nxt    = accept ? ex_nxt : st_r;
  assign r_lat_nxt = accept ? ex_r_nxt : r_lat_r;

  // write at this instruction's X/Y, read ahead at the X/Y it leaves
  always_comb begin
    ram_req.we = accept && ex_we;
    ram_req.wa = {st_r.x, st_r.y};
    ram_req.wd = ex_wd;
    ram_req.ra = {st_nxt.x, st_nxt.y};
  end

  fbmc_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (ram_m)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_RESET;
      r_lat_r <= '0;
    end else begin
      st_r    <= st_nxt;
      r_lat_r <= r_lat_nxt;
    end
  end

  // R field shows the low lines of the latch, zero above the latch width
  generate
    if (R_LINES > OUT_R_W) begin : g_r_wide
      assign r_view = ex_r_nxt[OUT_R_W-1:0];
    end else if (R_LINES == OUT_R_W) begin : g_r_same
      assign r_view = ex_r_nxt;
    end else begin : g_r_narrow
      assign r_view = {{(OUT_R_W-R_LINES){1'b0}}, ex_r_nxt};
    end
  endgenerate

  always_comb begin
    res.fetch_address = {ex_nxt.ca, ex_nxt.pa, ex_nxt.pc};
    res.r_lines       = r_view;
    res.o_lines       = ex_nxt.o;
    res.status        = ex_nxt.s;
  end

  fbmc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/fbmc_checker.sv
// fbmc_checker: port-level assertions for the four-bit core, bound to the top.
// Uses fbmc_pkg for the payload types.
`default_nettype none

module fbmc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire fbmc_pkg::out_item_t out_data
);
  import fbmc_pkg::*;

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

  // a request into an empty output shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("result missing one cycle after request");

  // backpressure only with a full output stage
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("request refused with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind four_bit_microcontroller_core fbmc_checker u_fbmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
